[rtl/slot_id_free_list_allocator_macros.svh]
// Assertion macros for the slot identifier allocator.
// Included by the top level; expects signals clk and rst in scope.
`ifndef SLOT_ID_FREE_LIST_ALLOCATOR_MACROS_SVH
`define SLOT_ID_FREE_LIST_ALLOCATOR_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define SIDFL_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that must hold in the cycle after the antecedent.
`define SIDFL_IMPLIES_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/sidfl_pkg.sv]
// Package for the slot identifier allocator: sizes, codes and cell control.
// Used by sidfl_cell and slot_id_free_list_allocator; depends on nothing.
package sidfl_pkg;

  localparam int MAX_SLOTS   = 64;
  localparam int ID_W        = $clog2(MAX_SLOTS);
  localparam int COUNT_W     = 7;
  localparam int SLOTS_RESET = 64;

  typedef enum logic [1:0] {
    KIND_CREATE = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_REMOVE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_EXHAUSTED    = 2'd1,
    ST_SETUP_FAILED = 2'd2,
    ST_ABSENT       = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    STK_HOLD,
    STK_POP,
    STK_PUSH,
    STK_RESTART
  } stk_op_t;

  typedef struct packed {
    stk_op_t         op;
    logic [ID_W-1:0] push_id;
    logic            occ_set;
    logic            occ_clr;
    logic [ID_W-1:0] target;
  } cell_ctrl_t;

endpackage

[rtl/sidfl_cell.sv]
// One cell of the allocator row: a free-list stack entry and the occupied flag
// of the identifier equal to the cell's index. Depends on sidfl_pkg.
module sidfl_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  sidfl_pkg::cell_ctrl_t       ctrl,
  input  logic [sidfl_pkg::ID_W-1:0]  index,
  input  logic [sidfl_pkg::ID_W-1:0]  above,
  input  logic [sidfl_pkg::ID_W-1:0]  below,
  output logic [sidfl_pkg::ID_W-1:0]  value,
  output logic                        occ
);

  logic hit;

  assign hit = (ctrl.target == index);

  always_ff @(posedge clk) begin
    if (rst || ctrl.op == sidfl_pkg::STK_RESTART) begin
      value <= index;
      occ   <= 1'b0;
    end else begin
      case (ctrl.op)
        sidfl_pkg::STK_POP:  value <= below;
        sidfl_pkg::STK_PUSH: value <= above;
        default:             value <= value;
      endcase
      if (ctrl.occ_set && hit) begin
        occ <= 1'b1;
      end else if (ctrl.occ_clr && hit) begin
        occ <= 1'b0;
      end
    end
  end

endmodule

[rtl/slot_id_free_list_allocator.sv]
// A result is registered in the cycle after its item is accepted.
// Throughput: one item per cycle while in_stall is low; the free list is a row of
// cells that shifts by one place on each push or pop.
// Reset (synchronous, active high): 64 slots managed, identifiers 0 upward on
// the free list with 0 on top, no identifier occupied, no result pending.
// Top level of the slot identifier allocator; uses sidfl_pkg and sidfl_cell.
module slot_id_free_list_allocator (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] kind,
  input  logic [7:0] slot_id,
  input  logic       setup_ok,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [5:0] result_id,
  output logic [1:0] status,
  output logic [6:0] active_slots,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] cfg_data
);

  `include "slot_id_free_list_allocator_macros.svh"

  localparam int N  = sidfl_pkg::MAX_SLOTS;
  localparam int IW = sidfl_pkg::ID_W;
  localparam int CW = sidfl_pkg::COUNT_W;

  logic [CW-1:0] slots_in_use, slots_in_use_next;
  logic [CW-1:0] free_depth, free_depth_next;
  logic [CW-1:0] active_total, active_total_next;

  logic [IW-1:0] cell_value [N];
  logic [N-1:0]  occ_vec;

  sidfl_pkg::cell_ctrl_t ctrl;

  logic          accept;
  logic          cfg_write;
  logic [CW-1:0] cfg_clamped;
  logic [IW-1:0] top_id;
  logic [IW-1:0] id_low;
  logic          in_range;
  logic          occ_hit;
  logic [IW-1:0] res_id;
  logic [1:0]    res_status;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign in_stall  = out_valid && out_stall;
  assign accept    = in_valid && !in_stall;

  assign top_id   = cell_value[0];
  assign id_low   = slot_id[IW-1:0];
  assign in_range = ({1'b0, slot_id} < {2'b00, slots_in_use});
  assign occ_hit  = occ_vec[id_low];

  always_comb begin
    if (cfg_data == 7'd0) begin
      cfg_clamped = 7'd1;
    end else if (cfg_data > CW'(N)) begin
      cfg_clamped = CW'(N);
    end else begin
      cfg_clamped = cfg_data;
    end
  end

  always_comb begin
    ctrl.op           = sidfl_pkg::STK_HOLD;
    ctrl.push_id      = id_low;
    ctrl.occ_set      = 1'b0;
    ctrl.occ_clr      = 1'b0;
    ctrl.target       = id_low;
    slots_in_use_next = slots_in_use;
    free_depth_next   = free_depth;
    active_total_next = active_total;
    res_id            = '0;
    res_status        = sidfl_pkg::ST_ABSENT;
    if (cfg_write) begin
      ctrl.op           = sidfl_pkg::STK_RESTART;
      slots_in_use_next = cfg_clamped;
      free_depth_next   = cfg_clamped;
      active_total_next = '0;
    end else if (accept) begin
      case (kind)
        sidfl_pkg::KIND_CREATE: begin
          if (free_depth == '0) begin
            res_status = sidfl_pkg::ST_EXHAUSTED;
          end else if (!setup_ok) begin
            // Nothing is popped, so the top identifier stays on the free list.
            res_status = sidfl_pkg::ST_SETUP_FAILED;
          end else begin
            ctrl.op           = sidfl_pkg::STK_POP;
            ctrl.occ_set      = 1'b1;
            ctrl.target       = top_id;
            free_depth_next   = free_depth - CW'(1);
            active_total_next = active_total + CW'(1);
            res_id            = top_id;
            res_status        = sidfl_pkg::ST_OK;
          end
        end
        sidfl_pkg::KIND_LOOKUP: begin
          if (in_range && occ_hit) begin
            res_id     = id_low;
            res_status = sidfl_pkg::ST_OK;
          end
        end
        sidfl_pkg::KIND_REMOVE: begin
          if (in_range && occ_hit) begin
            ctrl.occ_clr = 1'b1;
            if (free_depth < CW'(N)) begin
              ctrl.op         = sidfl_pkg::STK_PUSH;
              free_depth_next = free_depth + CW'(1);
            end
            active_total_next = active_total - CW'(1);
            res_id            = id_low;
            res_status        = sidfl_pkg::ST_OK;
          end
        end
        default: begin
          res_status = sidfl_pkg::ST_ABSENT;
        end
      endcase
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [IW-1:0] above;
    logic [IW-1:0] below;
    if (i == 0) begin : g_first
      assign above = ctrl.push_id;
    end else begin : g_rest
      assign above = cell_value[i-1];
    end
    if (i == N - 1) begin : g_last
      assign below = cell_value[i];
    end else begin : g_inner
      assign below = cell_value[i+1];
    end
    sidfl_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .ctrl  (ctrl),
      .index (IW'(i)),
      .above (above),
      .below (below),
      .value (cell_value[i]),
      .occ   (occ_vec[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= CW'(sidfl_pkg::SLOTS_RESET);
      free_depth   <= CW'(sidfl_pkg::SLOTS_RESET);
      active_total <= '0;
      out_valid    <= 1'b0;
    end else begin
      slots_in_use <= slots_in_use_next;
      free_depth   <= free_depth_next;
      active_total <= active_total_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result_id    <= res_id;
      status       <= res_status;
      active_slots <= active_total_next;
    end
  end

  `SIDFL_ALWAYS(a_depth_plus_active, ({1'b0, free_depth} + {1'b0, active_total}) == {1'b0, slots_in_use}, "free list depth and active count do not add up to the slot count")
  `SIDFL_ALWAYS(a_occupied_count, $countones(occ_vec) == int'(active_total), "occupied table does not match the active count")
  `SIDFL_IMPLIES_NEXT(a_accept_gives_result, accept, out_valid, "accepted item produced no result")

endmodule

[tb/tb_slot_id_free_list_allocator.sv]
// Self-checking testbench for the slot identifier allocator with its LIFO free list.
// Depends on sidfl_pkg and slot_id_free_list_allocator; it mirrors the free list and
// the occupied table and checks each result while both sides idle and stall at random.
`timescale 1ns / 1ps

module tb_slot_id_free_list_allocator;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 1000;
  localparam int HOLDOFF_CYCLES = 200;

  typedef enum {STALL_NONE, STALL_RANDOM, STALL_HEAVY, STALL_ALTERNATE} stall_style_t;

  class slot_pool_mirror;
    typedef struct {
      logic [5:0]          id;
      sidfl_pkg::status_t  st;
      logic [6:0]          active;
    } reply_t;

    int         slot_count;
    bit [5:0]   free_ids[sidfl_pkg::MAX_SLOTS];
    int         free_depth;
    bit [63:0]  held;
    bit [6:0]   active;
    reply_t     expected_replies[$];
    int         mismatches;

    function new();
      mismatches = 0;
      set_slot_count(7'(sidfl_pkg::SLOTS_RESET));
    endfunction

    function void set_slot_count(logic [6:0] v);
      slot_count = (v == 0) ? 1 : (v > sidfl_pkg::MAX_SLOTS) ? sidfl_pkg::MAX_SLOTS : int'(v);
      held = '0;
      active = '0;
      free_depth = slot_count;
      for (int i = 0; i < sidfl_pkg::MAX_SLOTS; i++) begin
        free_ids[i] = (i < slot_count) ? 6'(slot_count - 1 - i) : 6'd0;
      end
    endfunction

    function void give_back(bit [5:0] id);
      if (free_depth < sidfl_pkg::MAX_SLOTS) begin
        free_ids[free_depth] = id;
        free_depth++;
      end
    endfunction

    function void accept_request(logic [1:0] k, logic [7:0] id, logic ok);
      reply_t r;
      bit [5:0] got;
      r.id = '0;
      r.st = sidfl_pkg::ST_ABSENT;
      if (k == sidfl_pkg::KIND_CREATE) begin
        if (free_depth == 0) begin
          r.st = sidfl_pkg::ST_EXHAUSTED;
        end else begin
          got = free_ids[free_depth - 1];
          free_depth--;
          if (!ok) begin
            give_back(got);
            r.st = sidfl_pkg::ST_SETUP_FAILED;
          end else begin
            held[got] = 1'b1;
            active++;
            r.id = got;
            r.st = sidfl_pkg::ST_OK;
          end
        end
      end else if ((k == sidfl_pkg::KIND_LOOKUP || k == sidfl_pkg::KIND_REMOVE)
                   && id < slot_count && held[id[5:0]]) begin
        r.id = id[5:0];
        r.st = sidfl_pkg::ST_OK;
        if (k == sidfl_pkg::KIND_REMOVE) begin
          held[id[5:0]] = 1'b0;
          give_back(id[5:0]);
          active--;
        end
      end
      r.active = active;
      expected_replies = {expected_replies, r};
    endfunction

    function void check_reply(logic [5:0] id, logic [1:0] st, logic [6:0] act);
      reply_t r;
      if (expected_replies.size() == 0) begin
        $error("result with no item outstanding: result_id %0d status %0d", id, st);
        mismatches++;
        return;
      end
      r = expected_replies.pop_front();
      if (id !== r.id) begin
        $error("result_id: expected %0d, actual %0d", r.id, id);
        mismatches++;
      end
      if (st !== r.st) begin
        $error("status: expected %0d, actual %0d", r.st, st);
        mismatches++;
      end
      if (act !== r.active) begin
        $error("active_slots: expected %0d, actual %0d", r.active, act);
        mismatches++;
      end
    endfunction

    function int held_id();
      int pick[$];
      for (int i = 0; i < slot_count; i++) begin
        if (held[i]) pick = {pick, i};
      end
      if (pick.size() == 0) return $urandom_range(slot_count - 1);
      return pick[$urandom_range(pick.size() - 1)];
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] kind = '0;
  logic [7:0] slot_id = '0;
  logic       setup_ok = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [5:0] result_id;
  logic [1:0] status;
  logic [6:0] active_slots;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [6:0] cfg_data = '0;

  slot_pool_mirror mirror;
  int           idle_cycles = 0;
  int           burst_left = 0;
  bit           holdoff_req = 1'b0;
  bit           holdoff_done = 1'b0;
  int           holdoff_left = 0;
  int           pattern_left = 0;
  bit [7:0]     pattern_tick = '0;
  stall_style_t stall_style = STALL_NONE;

  slot_id_free_list_allocator i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .kind(kind),
    .slot_id(slot_id),
    .setup_ok(setup_ok),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .result_id(result_id),
    .status(status),
    .active_slots(active_slots),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) mirror.set_slot_count(cfg_data);
      if (in_valid && !in_stall) mirror.accept_request(kind, slot_id, setup_ok);
      if (out_valid && !out_stall) mirror.check_reply(result_id, status, active_slots);
      if ((cfg_valid && cfg_ready) || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (holdoff_left > 0) begin
      out_stall <= 1'b1;
      holdoff_left--;
    end else if (holdoff_req && !holdoff_done) begin
      holdoff_done = 1'b1;
      holdoff_left = HOLDOFF_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      if (pattern_left == 0) begin
        stall_style = stall_style_t'($urandom_range(3));
        pattern_left = $urandom_range(16, 80);
      end
      pattern_left--;
      pattern_tick++;
      case (stall_style)
        STALL_NONE: out_stall <= 1'b0;
        STALL_RANDOM: out_stall <= ($urandom_range(1) == 1);
        STALL_HEAVY: out_stall <= (pattern_tick[1:0] != 2'd0);
        default: out_stall <= pattern_tick[0];
      endcase
    end
  end

  task automatic send_item(logic [1:0] k, logic [7:0] id, logic ok);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
    end
    burst_left--;
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    kind <= k;
    slot_id <= id;
    setup_ok <= ok;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drained();
    @(negedge clk) in_valid <= 1'b0;
    while (mirror.expected_replies.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_slot_count(logic [6:0] v);
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  task automatic random_item();
    int r;
    logic [1:0] k;
    logic [7:0] id;
    r = $urandom_range(99);
    if (r < 40) k = sidfl_pkg::KIND_CREATE;
    else if (r < 60) k = sidfl_pkg::KIND_LOOKUP;
    else if (r < 95) k = sidfl_pkg::KIND_REMOVE;
    else k = KIND_UNUSED;
    r = $urandom_range(99);
    if (r < 50) id = 8'(mirror.held_id());
    else if (r < 80) id = 8'($urandom_range(mirror.slot_count - 1));
    else id = 8'($urandom_range(255));
    send_item(k, id, $urandom_range(9) != 0);
  endtask

  initial begin
    logic [6:0] phase_counts[8];
    phase_counts = '{7'd127, 7'd1, 7'd2, 7'd5, 7'd64, 7'd13, 7'd100, 7'd33};
    mirror = new();
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    send_item(sidfl_pkg::KIND_CREATE, 8'd255, 1'b1);
    send_item(sidfl_pkg::KIND_CREATE, 8'd0, 1'b1);
    send_item(sidfl_pkg::KIND_CREATE, 8'd17, 1'b0);
    send_item(sidfl_pkg::KIND_CREATE, 8'd0, 1'b1);
    send_item(sidfl_pkg::KIND_LOOKUP, 8'd1, 1'b0);
    send_item(sidfl_pkg::KIND_LOOKUP, 8'd5, 1'b1);
    send_item(sidfl_pkg::KIND_LOOKUP, 8'd63, 1'b1);
    send_item(sidfl_pkg::KIND_LOOKUP, 8'd64, 1'b1);
    send_item(sidfl_pkg::KIND_LOOKUP, 8'd255, 1'b1);
    send_item(sidfl_pkg::KIND_REMOVE, 8'd1, 1'b0);
    send_item(sidfl_pkg::KIND_REMOVE, 8'd1, 1'b1);
    send_item(sidfl_pkg::KIND_REMOVE, 8'd200, 1'b1);
    send_item(sidfl_pkg::KIND_REMOVE, 8'd63, 1'b1);
    send_item(KIND_UNUSED, 8'd0, 1'b1);
    send_item(sidfl_pkg::KIND_CREATE, 8'd0, 1'b1);
    send_item(sidfl_pkg::KIND_REMOVE, 8'd0, 1'b1);
    send_item(sidfl_pkg::KIND_REMOVE, 8'd2, 1'b1);
    send_item(sidfl_pkg::KIND_REMOVE, 8'd1, 1'b1);

    write_slot_count(7'd0);
    send_item(sidfl_pkg::KIND_CREATE, 8'd0, 1'b1);
    send_item(sidfl_pkg::KIND_CREATE, 8'd0, 1'b1);
    send_item(sidfl_pkg::KIND_CREATE, 8'd0, 1'b0);
    send_item(sidfl_pkg::KIND_LOOKUP, 8'd0, 1'b1);
    send_item(sidfl_pkg::KIND_LOOKUP, 8'd1, 1'b1);
    send_item(sidfl_pkg::KIND_REMOVE, 8'd0, 1'b1);
    send_item(sidfl_pkg::KIND_CREATE, 8'd0, 1'b0);
    send_item(sidfl_pkg::KIND_CREATE, 8'd0, 1'b1);

    // The receiver holds off while creates keep coming, so the block backs up and
    // stalls its input; the creates that follow can run the free list dry.
    write_slot_count(7'd64);
    holdoff_req = 1'b1;
    repeat (70) begin
      send_item(sidfl_pkg::KIND_CREATE, 8'($urandom_range(255)), $urandom_range(9) != 0);
    end
    wait_drained();
    repeat (40) begin
      if ($urandom_range(4) == 0) random_item();
      else send_item(sidfl_pkg::KIND_REMOVE, 8'(mirror.held_id()), 1'b1);
    end

    foreach (phase_counts[p]) begin
      write_slot_count(phase_counts[p]);
      repeat (40) random_item();
    end

    wait_drained();
    if (mirror.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
